/* rtl/rrs_pkg.sv */
package rrs_pkg;
    localparam int KEY_W = 64;
    localparam int DIGIT_W = 8;
    localparam int BUCKETS = 256;
    localparam int PASSES = 8;
    localparam int CNT_W = 17;
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_FETCH = 1'b1;
endpackage

/* rtl/rrs_ram.sv */
module rrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/record_radix_sort.sv */
// Channel | Direction | Handshake         | Payload
// in      | input     | valid / ready     | command, key_sum, six date bytes, last_load
// out     | output    | out_valid / out_ready | record_index, sorted_sum, valid_res, final_record
// A load writes its record into the key RAM, and loads can follow back to back.
// A fetch reads via S_F_A, S_F_B, S_F_C into S_OUT; with no record due, valid_res is low.
// A last load starts the sort of the N stored records: the order RAM is seeded, then each pass
// clears the bucket counts, counts digits, forms prefix sums and scatters into the other bank.
// Reset clears the control state only; the RAMs keep undefined contents until written.
// While a result waits on out_ready, no new item is taken.
module record_radix_sort #(
    parameter int MAX_RECORDS = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        ready,
    input  logic        command,
    input  logic [15:0] key_sum,
    input  logic [7:0]  year_tens,
    input  logic [7:0]  year_ones,
    input  logic [7:0]  month_tens,
    input  logic [7:0]  month_ones,
    input  logic [7:0]  day_tens,
    input  logic [7:0]  day_ones,
    input  logic        last_load,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] record_index,
    output logic [15:0] sorted_sum,
    output logic        valid_res,
    output logic        final_record
);
    localparam int AW = (MAX_RECORDS > 2) ? $clog2(MAX_RECORDS) : 1;
    localparam int NW = $clog2(MAX_RECORDS + 1);
    localparam int BW = $clog2(rrs_pkg::BUCKETS);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_INIT = 4'd1;
    localparam logic [3:0] S_CLR = 4'd2;
    localparam logic [3:0] S_CNT_A = 4'd3;
    localparam logic [3:0] S_CNT_B = 4'd4;
    localparam logic [3:0] S_CNT_C = 4'd5;
    localparam logic [3:0] S_PRE_A = 4'd6;
    localparam logic [3:0] S_PRE_B = 4'd7;
    localparam logic [3:0] S_SC_A = 4'd8;
    localparam logic [3:0] S_SC_B = 4'd9;
    localparam logic [3:0] S_SC_C = 4'd10;
    localparam logic [3:0] S_SC_D = 4'd11;
    localparam logic [3:0] S_F_A = 4'd12;
    localparam logic [3:0] S_F_B = 4'd13;
    localparam logic [3:0] S_F_C = 4'd14;
    localparam logic [3:0] S_OUT = 4'd15;

    logic [3:0] state_reg, state_next;
    logic [NW-1:0] count_reg, count_next;
    logic [NW-1:0] fpos_reg, fpos_next;
    logic sorted_reg, sorted_next;
    logic [NW-1:0] i_reg, i_next;
    logic [BW:0] b_reg, b_next;
    logic [2:0] pass_reg, pass_next;
    logic bank_reg, bank_next;
    logic [NW-1:0] total_reg, total_next;
    logic [AW-1:0] r_reg, r_next;
    logic [BW-1:0] d_reg, d_next;
    logic [11:0] idx_reg, idx_next;
    logic [15:0] sum_reg, sum_next;
    logic vres_reg, vres_next;
    logic fin_reg, fin_next;

    logic k_we;
    logic [AW-1:0] k_wa, k_ra;
    logic [rrs_pkg::KEY_W-1:0] k_wd, k_rd;
    logic [1:0] o_we;
    logic [AW-1:0] o_wa [2];
    logic [AW-1:0] o_ra [2];
    logic [AW-1:0] o_wd [2];
    logic [AW-1:0] o_rd [2];
    logic c_we;
    logic [BW-1:0] c_wa, c_ra;
    logic [NW-1:0] c_wd, c_rd;
    logic [BW-1:0] digit;
    logic [rrs_pkg::KEY_W-1:0] load_key;

    rrs_ram #(.WIDTH(rrs_pkg::KEY_W), .DEPTH(MAX_RECORDS)) u_keys (
        .clk(clk), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd));
    rrs_ram #(.WIDTH(AW), .DEPTH(MAX_RECORDS)) u_ord0 (
        .clk(clk), .we(o_we[0]), .waddr(o_wa[0]), .wdata(o_wd[0]), .raddr(o_ra[0]),
        .rdata(o_rd[0]));
    rrs_ram #(.WIDTH(AW), .DEPTH(MAX_RECORDS)) u_ord1 (
        .clk(clk), .we(o_we[1]), .waddr(o_wa[1]), .wdata(o_wd[1]), .raddr(o_ra[1]),
        .rdata(o_rd[1]));
    rrs_ram #(.WIDTH(NW), .DEPTH(rrs_pkg::BUCKETS)) u_bkt (
        .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));

    assign load_key = {key_sum, year_tens, year_ones, month_tens, month_ones, day_tens,
        day_ones};
    assign digit = BW'(k_rd >> {pass_reg, 3'b000});
    assign ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign record_index = idx_reg;
    assign sorted_sum = sum_reg;
    assign valid_res = vres_reg;
    assign final_record = fin_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        fpos_next = fpos_reg;
        sorted_next = sorted_reg;
        i_next = i_reg;
        b_next = b_reg;
        pass_next = pass_reg;
        bank_next = bank_reg;
        total_next = total_reg;
        r_next = r_reg;
        d_next = d_reg;
        idx_next = idx_reg;
        sum_next = sum_reg;
        vres_next = vres_reg;
        fin_next = fin_reg;
        k_we = 1'b0;
        k_wa = AW'(count_reg);
        k_wd = load_key;
        k_ra = r_reg;
        o_we = 2'b00;
        o_wa[0] = AW'(i_reg);
        o_wa[1] = AW'(i_reg);
        o_wd[0] = AW'(i_reg);
        o_wd[1] = AW'(i_reg);
        o_ra[0] = AW'(i_reg);
        o_ra[1] = AW'(i_reg);
        c_we = 1'b0;
        c_wa = BW'(b_reg);
        c_wd = '0;
        c_ra = BW'(b_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (valid)
                begin
                    if (command == rrs_pkg::CMD_LOAD)
                    begin
                        if (sorted_reg)
                        begin
                            count_next = '0;
                            fpos_next = '0;
                            sorted_next = 1'b0;
                            k_wa = '0;
                        end
                        if (!sorted_reg && count_reg < NW'(MAX_RECORDS))
                        begin
                            k_we = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                        else if (sorted_reg)
                        begin
                            k_we = 1'b1;
                            count_next = NW'(1);
                        end
                        if (last_load)
                        begin
                            state_next = S_INIT;
                            i_next = '0;
                        end
                    end
                    else
                    begin
                        idx_next = '0;
                        sum_next = '0;
                        vres_next = 1'b0;
                        fin_next = 1'b0;
                        if (sorted_reg && fpos_reg < count_reg)
                        begin
                            state_next = S_F_A;
                        end
                        else
                        begin
                            state_next = S_OUT;
                        end
                    end
                end
            end
            S_INIT:
            begin
                if (i_reg == count_reg)
                begin
                    state_next = S_CLR;
                    pass_next = '0;
                    bank_next = 1'b0;
                    b_next = '0;
                end
                else
                begin
                    o_we[0] = 1'b1;
                    i_next = i_reg + 1'b1;
                end
            end
            S_CLR:
            begin
                c_we = 1'b1;
                b_next = b_reg + 1'b1;
                if (b_reg == (BW+1)'(rrs_pkg::BUCKETS - 1))
                begin
                    state_next = S_CNT_A;
                    i_next = '0;
                end
            end
            S_CNT_A:
            begin
                if (i_reg == count_reg)
                begin
                    state_next = S_PRE_A;
                    b_next = '0;
                    total_next = '0;
                end
                else
                begin
                    state_next = S_CNT_B;
                end
            end
            S_CNT_B:
            begin
                k_ra = o_rd[bank_reg];
                state_next = S_CNT_C;
            end
            S_CNT_C:
            begin
                c_ra = digit;
                d_next = digit;
                state_next = S_SC_D;
                r_next = '0;
            end
            S_PRE_A:
            begin
                state_next = S_PRE_B;
            end
            S_PRE_B:
            begin
                c_we = 1'b1;
                c_wd = total_reg;
                total_next = total_reg + c_rd;
                b_next = b_reg + 1'b1;
                if (b_reg == (BW+1)'(rrs_pkg::BUCKETS - 1))
                begin
                    state_next = S_SC_A;
                    i_next = '0;
                end
                else
                begin
                    state_next = S_PRE_A;
                    c_ra = BW'(b_reg + 1'b1);
                end
            end
            S_SC_A:
            begin
                if (i_reg == count_reg)
                begin
                    bank_next = !bank_reg;
                    if (pass_reg == 3'(rrs_pkg::PASSES - 1))
                    begin
                        state_next = S_IDLE;
                        sorted_next = 1'b1;
                        fpos_next = '0;
                        pass_next = '0;
                    end
                    else
                    begin
                        pass_next = pass_reg + 1'b1;
                        state_next = S_CLR;
                        b_next = '0;
                    end
                end
                else
                begin
                    state_next = S_SC_B;
                end
            end
            S_SC_B:
            begin
                k_ra = o_rd[bank_reg];
                r_next = o_rd[bank_reg];
                state_next = S_SC_C;
            end
            S_SC_C:
            begin
                c_ra = digit;
                d_next = digit;
                r_next = r_reg;
                state_next = S_SC_D;
                i_next = i_reg;
                b_next = {1'b1, {BW{1'b0}}};
            end
            S_SC_D:
            begin
                c_we = 1'b1;
                c_wa = d_reg;
                c_wd = c_rd + 1'b1;
                i_next = i_reg + 1'b1;
                if (b_reg[BW])
                begin
                    o_we[!bank_reg] = 1'b1;
                    o_wa[!bank_reg] = AW'(c_rd);
                    o_wd[!bank_reg] = r_reg;
                    state_next = S_SC_A;
                end
                else
                begin
                    state_next = S_CNT_A;
                end
                o_ra[bank_reg] = AW'(i_reg + 1'b1);
            end
            S_F_A:
            begin
                o_ra[bank_reg] = AW'(fpos_reg);
                state_next = S_F_B;
            end
            S_F_B:
            begin
                k_ra = o_rd[bank_reg];
                idx_next = 12'(o_rd[bank_reg]);
                state_next = S_F_C;
            end
            S_F_C:
            begin
                sum_next = k_rd[63:48];
                vres_next = 1'b1;
                fin_next = (fpos_reg + 1'b1 == count_reg);
                fpos_next = fpos_reg + 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (state_reg == S_CNT_A || state_reg == S_SC_A)
        begin
            o_ra[bank_reg] = AW'(i_reg);
        end
        if (state_reg == S_CNT_A)
        begin
            b_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            fpos_reg <= '0;
            sorted_reg <= 1'b0;
            i_reg <= '0;
            b_reg <= '0;
            pass_reg <= '0;
            bank_reg <= 1'b0;
            vres_reg <= 1'b0;
            fin_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            fpos_reg <= fpos_next;
            sorted_reg <= sorted_next;
            i_reg <= i_next;
            b_reg <= b_next;
            pass_reg <= pass_next;
            bank_reg <= bank_next;
            vres_reg <= vres_next;
            fin_reg <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg <= total_next;
        r_reg <= r_next;
        d_reg <= d_next;
        idx_reg <= idx_next;
        sum_reg <= sum_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(MAX_RECORDS)) else $error("record count exceeds capacity");
    a_fetch_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fpos_reg <= count_reg) else $error("fetch position past record count");
    a_final_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && final_record |-> valid_res) else $error("final flag without record");
endmodule
